/* design/asd_pkg.sv */
// Shared types, constants and sequencer states of the angle smoothing block.
package asd_pkg;

    // Configuration register indexes
    localparam int unsigned REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_DOUBLE_INVERSE_TIME = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHANGE_LIMIT        = 1'd1;

    localparam logic [15:0] DOUBLE_INVERSE_TIME_RST = 16'd1280;
    localparam logic [15:0] CHANGE_LIMIT_RST        = 16'd25736;

    // Half and full turn in Q13 radians
    localparam logic signed [17:0] PI_Q13   = 18'sd25736;
    localparam logic signed [17:0] TURN_Q13 = 18'sd51472;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 45;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Cubic coefficients 0.48 and 0.235 in Q0.16
    localparam logic [MUL_B_W-1:0] C048_Q16  = 25'd31457;
    localparam logic [MUL_B_W-1:0] C0235_Q16 = 25'd15401;

    // Reciprocal divider: 2^32 / den with den >= 2^16, so the quotient has 17 bits
    localparam int DEN_W  = 40;
    localparam int QUOT_W = 17;
    localparam logic [DEN_W-1:0] DIV_REM_INIT = DEN_W'(64'd1 << (32 - QUOT_W));

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_X,
        ST_X2,
        ST_X3,
        ST_K2,
        ST_K3,
        ST_T0,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_WAIT,
        ST_V0,
        ST_V1,
        ST_OUT
    } state_t;

endpackage

/* design/asd_mul.sv */
// Shared signed multiplier with a registered product.
module asd_mul (
    input  logic                                clk,
    input  asd_pkg::mul_req_t                   req,
    output logic signed [asd_pkg::MUL_P_W-1:0]  prod
);

    logic signed [asd_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= $signed(req.a) * $signed(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

/* design/asd_div.sv */
// Restoring divider that forms 2^32 / den one quotient bit per cycle.
module asd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  asd_pkg::div_req_t  req,
    output asd_pkg::div_stat_t stat
);

    localparam logic [4:0] LAST_STEP = 5'(asd_pkg::QUOT_W - 1);

    logic                        busy_reg;
    logic [4:0]                  cnt_reg;
    logic [asd_pkg::DEN_W-1:0]   den_reg;
    logic [asd_pkg::DEN_W-1:0]   rem_reg;
    logic [asd_pkg::QUOT_W-1:0]  quot_reg;

    logic [asd_pkg::DEN_W:0]     rem_dbl;
    logic [asd_pkg::DEN_W:0]     rem_sub;
    logic                        fits;

    // The dividend has no bits below bit 32, so each step only doubles the remainder.
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_sub = rem_dbl - {1'b0, den_reg};
    assign fits    = (rem_dbl >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= LAST_STEP;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.den;
            rem_reg <= asd_pkg::DIV_REM_INIT;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? rem_sub[asd_pkg::DEN_W-1:0] : rem_dbl[asd_pkg::DEN_W-1:0];
            quot_reg <= {quot_reg[asd_pkg::QUOT_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.quot = quot_reg;

endmodule

/* design/angle_smooth_damp_top.sv */
// Top level: critically damped smoothing of an angle toward a target angle.
//
// Input channel s_*: one word per update holds the current angle, the target
// angle and the time step. Output channel m_*: one word per input word holds
// the smoothed angle. The block also keeps the angular velocity between words.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while the block
// is idle; index 0 is two over the smoothing time, index 1 the change limit.
//
// A sequencer drives one shared registered multiplier through the polynomial,
// velocity and output products, and a bit-serial divider forms the reciprocal
// of the decay polynomial in 17 steps. A new input word is taken only when the
// sequencer has returned to idle after the previous update.
//
// The result sits in an output register, so the block accepts the next word
// while the previous result still waits; if the receiver stalls longer, the
// sequencer holds its last step until the output register is free.
// Reset clears the velocity, loads the default configuration and empties the
// output register.
module angle_smooth_damp_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // current_angle, target_angle, time_step
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // smoothed_angle, zero fill
    input  logic                          cfg_we,
    input  logic [asd_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [15:0]                   cfg_wdata
);

    asd_pkg::state_t state_reg;
    asd_pkg::state_t state_next;

    logic [15:0]        omega_reg;
    logic [15:0]        limit_reg;
    logic signed [31:0] vel_reg;

    logic signed [17:0] cur_reg;
    logic signed [15:0] tgt_reg;
    logic [15:0]        dt_reg;
    logic signed [16:0] c_reg;
    logic signed [18:0] to_reg;
    logic [23:0]        x_reg;
    logic [31:0]        x2_reg;
    logic [39:0]        x3_reg;
    logic [39:0]        acc_reg;
    logic [39:0]        den_reg;
    logic signed [32:0] s_reg;
    logic signed [33:0] t_reg;
    logic signed [44:0] w_reg;
    logic signed [34:0] u_reg;

    logic               out_valid_reg;
    logic signed [17:0] out_reg;

    asd_pkg::mul_req_t  mul_req;
    asd_pkg::div_req_t  div_req;
    asd_pkg::div_stat_t div_stat;
    logic signed [asd_pkg::MUL_P_W-1:0] prod;

    logic               accept;
    logic               out_free;
    logic               load_out;

    logic signed [15:0] in_cur;
    logic signed [15:0] in_tgt;
    logic signed [17:0] in_diff;
    logic signed [17:0] in_cur_ext;
    logic signed [17:0] cur_wrapped;

    logic signed [18:0] cur_ext;
    logic signed [18:0] d_full;
    logic signed [18:0] lim_ext;
    logic signed [18:0] c_full;
    logic signed [18:0] c_ext;

    logic signed [53:0] vel_prod;
    logic signed [31:0] vel_sat;
    logic signed [51:0] res_full;
    logic signed [17:0] res_sat;

    asd_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    asd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    assign s_tready = (state_reg == asd_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign load_out = (state_reg == asd_pkg::ST_OUT) && out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg};

    // Move the current angle by one turn when the difference exceeds half a turn.
    assign in_cur     = $signed(s_tdata[15:0]);
    assign in_tgt     = $signed(s_tdata[31:16]);
    assign in_cur_ext = {{2{in_cur[15]}}, in_cur};
    assign in_diff    = {{2{in_tgt[15]}}, in_tgt} - in_cur_ext;

    always_comb
    begin
        if (in_diff > asd_pkg::PI_Q13)
        begin
            cur_wrapped = in_cur_ext + asd_pkg::TURN_Q13;
        end
        else if (in_diff < -asd_pkg::PI_Q13)
        begin
            cur_wrapped = in_cur_ext - asd_pkg::TURN_Q13;
        end
        else
        begin
            cur_wrapped = in_cur_ext;
        end
    end

    assign cur_ext = {cur_reg[17], cur_reg};
    assign d_full  = cur_ext - {{3{tgt_reg[15]}}, tgt_reg};
    assign lim_ext = $signed({3'b0, limit_reg});
    assign c_ext   = {{2{c_reg[16]}}, c_reg};

    always_comb
    begin
        if (d_full > lim_ext)
        begin
            c_full = lim_ext;
        end
        else if (d_full < -lim_ext)
        begin
            c_full = -lim_ext;
        end
        else
        begin
            c_full = d_full;
        end
    end

    // Saturation of the new velocity and of the output angle.
    assign vel_prod = prod[69:16];

    always_comb
    begin
        if ((&vel_prod[53:31]) || !(|vel_prod[53:31]))
        begin
            vel_sat = vel_prod[31:0];
        end
        else if (vel_prod[53])
        begin
            vel_sat = 32'sh8000_0000;
        end
        else
        begin
            vel_sat = 32'sh7fff_ffff;
        end
    end

    assign res_full = {{33{to_reg[18]}}, to_reg} + {prod[69], prod[69:19]};

    always_comb
    begin
        if ((&res_full[51:17]) || !(|res_full[51:17]))
        begin
            res_sat = res_full[17:0];
        end
        else if (res_full[51])
        begin
            res_sat = 18'sh20000;
        end
        else
        begin
            res_sat = 18'sh1ffff;
        end
    end

    // Sequencer: state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state and multiplier/divider requests. A product issued
    // in one step is read from the multiplier register in the next step.
    always_comb
    begin
        state_next    = state_reg;
        mul_req       = '0;
        div_req.start = 1'b0;
        div_req.den   = den_reg;
        unique case (state_reg)
            asd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = asd_pkg::ST_CLAMP;
                end
            end
            asd_pkg::ST_CLAMP:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {29'b0, omega_reg};
                mul_req.b  = {9'b0, dt_reg};
                state_next = asd_pkg::ST_X;
            end
            asd_pkg::ST_X:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {21'b0, prod[31:8]};
                mul_req.b  = {1'b0, prod[31:8]};
                state_next = asd_pkg::ST_X2;
            end
            asd_pkg::ST_X2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {13'b0, prod[47:16]};
                mul_req.b  = {1'b0, x_reg};
                state_next = asd_pkg::ST_X3;
            end
            asd_pkg::ST_X3:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {13'b0, x2_reg};
                mul_req.b  = asd_pkg::C048_Q16;
                state_next = asd_pkg::ST_K2;
            end
            asd_pkg::ST_K2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {5'b0, x3_reg};
                mul_req.b  = asd_pkg::C0235_Q16;
                state_next = asd_pkg::ST_K3;
            end
            asd_pkg::ST_K3:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {{28{c_reg[16]}}, c_reg};
                mul_req.b  = {9'b0, omega_reg};
                state_next = asd_pkg::ST_T0;
            end
            asd_pkg::ST_T0:
            begin
                div_req.start = 1'b1;
                state_next    = asd_pkg::ST_T1;
            end
            asd_pkg::ST_T1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {{12{s_reg[32]}}, s_reg};
                mul_req.b  = {9'b0, dt_reg};
                state_next = asd_pkg::ST_T2;
            end
            asd_pkg::ST_T2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {{11{prod[49]}}, prod[49:16]};
                mul_req.b  = {9'b0, omega_reg};
                state_next = asd_pkg::ST_T3;
            end
            asd_pkg::ST_T3:
            begin
                state_next = asd_pkg::ST_WAIT;
            end
            asd_pkg::ST_WAIT:
            begin
                if (!div_stat.busy)
                begin
                    state_next = asd_pkg::ST_V0;
                end
            end
            asd_pkg::ST_V0:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = w_reg;
                mul_req.b  = {8'b0, div_stat.quot};
                state_next = asd_pkg::ST_V1;
            end
            asd_pkg::ST_V1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {{10{u_reg[34]}}, u_reg};
                mul_req.b  = {8'b0, div_stat.quot};
                state_next = asd_pkg::ST_OUT;
            end
            asd_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = asd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asd_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration registers and kept velocity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omega_reg <= asd_pkg::DOUBLE_INVERSE_TIME_RST;
            limit_reg <= asd_pkg::CHANGE_LIMIT_RST;
            vel_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    asd_pkg::REG_DOUBLE_INVERSE_TIME: omega_reg <= cfg_wdata;
                    asd_pkg::REG_CHANGE_LIMIT:        limit_reg <= cfg_wdata;
                endcase
            end
            if (state_reg == asd_pkg::ST_V1)
            begin
                vel_reg <= vel_sat;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= res_sat;
        end
    end

    // Working registers of one update
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= cur_wrapped;
            tgt_reg <= in_tgt;
            dt_reg  <= s_tdata[47:32];
        end
        case (state_reg)
            asd_pkg::ST_CLAMP:
            begin
                c_reg <= c_full[16:0];
            end
            asd_pkg::ST_X:
            begin
                x_reg  <= prod[31:8];
                to_reg <= cur_ext - c_ext;
            end
            asd_pkg::ST_X2:
            begin
                x2_reg <= prod[47:16];
            end
            asd_pkg::ST_X3:
            begin
                x3_reg <= prod[55:16];
            end
            asd_pkg::ST_K2:
            begin
                acc_reg <= 40'd65536 + {16'b0, x_reg} + {9'b0, prod[46:16]};
            end
            asd_pkg::ST_K3:
            begin
                den_reg <= acc_reg + {2'b0, prod[53:16]};
            end
            asd_pkg::ST_T0:
            begin
                s_reg <= {vel_reg[31], vel_reg} + {{5{prod[32]}}, prod[32:5]};
            end
            asd_pkg::ST_T2:
            begin
                t_reg <= prod[49:16];
            end
            asd_pkg::ST_T3:
            begin
                w_reg <= {{13{vel_reg[31]}}, vel_reg} - {prod[51], prod[51:8]};
                u_reg <= {{15{c_reg[16]}}, c_reg, 3'b0} + {t_reg[33], t_reg};
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* design/asd_checker.sv */
// Port-level checker for the angle smoothing block and its bind to the top level.
module asd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // The output register is empty once reset has been applied at a clock edge.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output word valid during reset");

    // Once a word is taken, the input is not ready at two sampled points of its update.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##4 !s_tready)
        else $error("input accepted again too early");

    // A fresh result only comes out of the final step, never while idle.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an update in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output word changed or dropped");

endmodule

bind angle_smooth_damp_top asd_checker u_asd_checker (.*);
